// ----- src/pbfu_pkg.sv -----
package pbfu_pkg;

   localparam int WORD_BITS   = 64;
   localparam int POS_W       = $clog2(WORD_BITS) + 1;
   localparam int VALUE_W     = 16;
   localparam int WIDTH_REG_W = 5;
   localparam int COUNT_W     = 32;
   localparam int CARRY_CNT_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ELEMENT_WIDTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ELEMENT_COUNT = CSR_INDEX_W'(1);

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(9);
   localparam logic [COUNT_W-1:0]     COUNT_RESET = COUNT_W'(1);

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } pbfu_csr_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } pbfu_rsp_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic word_pop;
   } pbfu_stat_type;

endpackage

// ----- src/pbfu_front.sv -----
module pbfu_front
   import pbfu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WORD_BITS-1:0] push_word,
   output logic                 full,
   input  logic                 pop,
   output logic                 word_valid,
   output logic [WORD_BITS-1:0] word_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign word_valid = (count_ff != '0);
   assign word_data  = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && word_valid;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- src/pbfu_back.sv -----
module pbfu_back
   import pbfu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  pbfu_csr_type         csr,
   input  logic                 word_valid,
   input  logic [WORD_BITS-1:0] word_data,
   output logic                 word_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output pbfu_rsp_type         rsp_data,
   output pbfu_stat_type        stat
);

   logic [WIDTH_REG_W-1:0] width_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [VALUE_W-1:0]     carry_ff, carry_in;
   logic [CARRY_CNT_W-1:0] carry_cnt_ff, carry_cnt_in;
   logic [COUNT_W-1:0]     emitted_ff, emitted_in;
   logic [POS_W-2:0]       pos_ff, pos_in;

   logic [WIDTH_REG_W-1:0] w_eff;
   logic [COUNT_W-1:0]     count_eff;
   logic [VALUE_W:0]       mask_wide;
   logic [VALUE_W-1:0]     mask;
   logic [WORD_BITS-1:0]   at_pos;
   logic [WORD_BITS-1:0]   tail;
   logic [VALUE_W-1:0]     joined;
   logic [VALUE_W-1:0]     value;
   logic [POS_W-1:0]       pos_nx;
   logic [POS_W-1:0]       rem;
   logic                   go;
   logic                   is_last;
   logic                   need_pop;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_REG_W'(1);
      end else if (width_ff > WIDTH_REG_W'(VALUE_W)) begin
         w_eff = WIDTH_REG_W'(VALUE_W);
      end else begin
         w_eff = width_ff;
      end
      count_eff = (count_ff == '0) ? COUNT_W'(1) : count_ff;
      mask_wide = ((VALUE_W+1)'(1) << w_eff) - (VALUE_W+1)'(1);
      mask      = mask_wide[VALUE_W-1:0];

      at_pos = word_data >> pos_ff;
      joined = carry_ff | VALUE_W'(word_data[VALUE_W-1:0] << carry_cnt_ff);

      // a carried element is finished from the low bits of the new word
      if (pos_ff == '0 && carry_cnt_ff != '0) begin
         value  = joined & mask;
         pos_nx = POS_W'(w_eff) - POS_W'(carry_cnt_ff);
      end else begin
         value  = at_pos[VALUE_W-1:0] & mask;
         pos_nx = POS_W'(pos_ff) + POS_W'(w_eff);
      end

      rem      = POS_W'(WORD_BITS) - pos_nx;
      tail     = word_data >> pos_nx;
      go       = word_valid && !rsp_full;
      is_last  = (COUNT_W'(emitted_ff + 1'b1) == count_eff);
      need_pop = (rem < POS_W'(w_eff)) || is_last;

      emitted_in   = emitted_ff;
      pos_in       = pos_ff;
      carry_in     = carry_ff;
      carry_cnt_in = carry_cnt_ff;
      if (go) begin
         emitted_in = is_last ? '0 : COUNT_W'(emitted_ff + 1'b1);
         if (need_pop) begin
            pos_in = '0;
            // padding after the final element is dropped
            carry_in     = is_last ? '0 : tail[VALUE_W-1:0];
            carry_cnt_in = is_last ? '0 : rem[CARRY_CNT_W-1:0];
         end else begin
            pos_in       = pos_nx[POS_W-2:0];
            carry_in     = '0;
            carry_cnt_in = '0;
         end
      end
   end

   assign word_pop       = go && need_pop;
   assign rsp_push       = go;
   assign rsp_data.value = value;
   assign rsp_data.last  = is_last;
   assign stat.emit      = go;
   assign stat.last      = is_last;
   assign stat.word_pop  = word_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         count_ff     <= COUNT_RESET;
         carry_ff     <= '0;
         carry_cnt_ff <= '0;
         emitted_ff   <= '0;
         pos_ff       <= '0;
      end else if (csr.we) begin
         case (csr.index)
            REG_ELEMENT_WIDTH: begin
               width_ff     <= csr.data[WIDTH_REG_W-1:0];
               carry_ff     <= '0;
               carry_cnt_ff <= '0;
               emitted_ff   <= '0;
               pos_ff       <= '0;
            end
            REG_ELEMENT_COUNT: begin
               count_ff     <= csr.data[COUNT_W-1:0];
               carry_ff     <= '0;
               carry_cnt_ff <= '0;
               emitted_ff   <= '0;
               pos_ff       <= '0;
            end
            default: begin
            end
         endcase
      end else begin
         carry_ff     <= carry_in;
         carry_cnt_ff <= carry_cnt_in;
         emitted_ff   <= emitted_in;
         pos_ff       <= pos_in;
      end
   end

endmodule

// ----- src/pbfu_rsp_queue.sv -----
module pbfu_rsp_queue
   import pbfu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pbfu_rsp_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output pbfu_rsp_type head
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pbfu_rsp_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/packed_bit_field_unpacker.sv -----
// Unpacks a little-endian packed bit stream of 64-bit words into zero-extended
// elements of element_width bits (1 to 16), flagging the element_count-th
// element as last and dropping the rest of that word. Elements that straddle
// two words are carried over and completed from the next word. Words enter a
// two-beat queue; the unpack engine emits one element per cycle into a
// four-beat result queue while a word is queued and that queue has room, and
// frees a word with the last element it ends (about 64/width). Writing
// either register restarts the stream; write only while the block is idle.
module packed_bit_field_unpacker
   import pbfu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [WORD_BITS-1:0]   req_packed_word,
   output logic                   empty,
   input  logic                   pop,
   output logic [VALUE_W-1:0]     rsp_value,
   output logic                   rsp_last,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   pbfu_csr_type         csr;
   pbfu_rsp_type         eng_rsp;
   pbfu_rsp_type         head;
   pbfu_stat_type        stat;
   logic                 word_valid;
   logic [WORD_BITS-1:0] word_data;
   logic                 word_pop;
   logic                 rsp_full;
   logic                 rsp_push;

   assign csr.we    = csr_write_enable;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   pbfu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (req_packed_word),
      .full       (full),
      .pop        (word_pop),
      .word_valid (word_valid),
      .word_data  (word_data)
   );

   pbfu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .word_valid (word_valid),
      .word_data  (word_data),
      .word_pop   (word_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_data   (eng_rsp),
      .stat       (stat)
   );

   pbfu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (eng_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   assign rsp_value = head.value;
   assign rsp_last  = head.last;

`ifndef SYNTHESIS
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      stat.emit |-> !rsp_full)
      else $error("element emitted into a full result queue");

   a_last_drops_word: assert property (@(posedge clock) disable iff (reset)
      (stat.emit && stat.last) |-> stat.word_pop)
      else $error("final element did not release its word");

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      stat.word_pop |-> word_valid)
      else $error("word released with no word queued");
`endif

endmodule

// ----- verif/tb_packed_bit_field_unpacker.sv -----
`timescale 1ns / 1ps

module tb_packed_bit_field_unpacker;
   import pbfu_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = CSR_INDEX_W'(3);
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 420;

   class element_scoreboard;
      logic [WIDTH_REG_W-1:0] width_reg;
      logic [COUNT_W-1:0]     count_reg;
      logic [WORD_BITS-1:0]   carry_bits;
      int unsigned            carry_cnt;
      logic [COUNT_W-1:0]     emitted;
      pbfu_rsp_type           pending_elements[$];
      int                     errors;

      function new();
         width_reg = WIDTH_RESET;
         count_reg = COUNT_RESET;
         errors = 0;
         restart();
      endfunction

      function void restart();
         carry_bits = '0;
         carry_cnt = 0;
         emitted = '0;
      endfunction

      function logic [WORD_BITS-1:0] low_bits(int unsigned n);
         if (n >= WORD_BITS)
            return '1;
         return (64'd1 << n) - 64'd1;
      endfunction

      function void apply_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == REG_ELEMENT_WIDTH) begin
            width_reg = data[WIDTH_REG_W-1:0];
            restart();
         end else if (index == REG_ELEMENT_COUNT) begin
            count_reg = data;
            restart();
         end
      endfunction

      // returns 1 when this element closes the stream
      function bit emit_element(logic [WORD_BITS-1:0] v, logic [COUNT_W-1:0] total);
         pbfu_rsp_type e;
         e.value = v[VALUE_W-1:0];
         e.last = (emitted + 32'd1 == total);
         pending_elements.push_back(e);
         if (e.last)
            restart();
         else
            emitted++;
         return e.last;
      endfunction

      function void absorb_word(logic [WORD_BITS-1:0] word);
         int unsigned          w;
         int unsigned          pos;
         int unsigned          need;
         logic [COUNT_W-1:0]   total;
         logic [WORD_BITS-1:0] v;
         w = width_reg;
         if (w == 0)
            w = 1;
         else if (w > VALUE_W)
            w = VALUE_W;
         total = (count_reg == 0) ? COUNT_W'(1) : count_reg;
         pos = 0;
         if (carry_cnt != 0 && carry_cnt < w) begin
            // finish the element that straddled the previous word
            need = w - carry_cnt;
            v = (carry_bits | ((word & low_bits(need)) << carry_cnt)) & low_bits(w);
            carry_bits = '0;
            carry_cnt = 0;
            pos = need;
            if (emit_element(v, total))
               return;
         end else begin
            carry_bits = '0;
            carry_cnt = 0;
         end
         while (pos < WORD_BITS && WORD_BITS - pos >= w) begin
            v = (word >> pos) & low_bits(w);
            pos += w;
            if (emit_element(v, total))
               return;
         end
         if (pos < WORD_BITS) begin
            carry_bits = (word >> pos) & low_bits(WORD_BITS - pos);
            carry_cnt = WORD_BITS - pos;
         end
      endfunction

      function void note_mismatch(string msg);
         errors++;
         if (errors <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
      endfunction

      function void check_element(logic [VALUE_W-1:0] value, logic last);
         pbfu_rsp_type e;
         if (pending_elements.size() == 0) begin
            note_mismatch($sformatf("unexpected element value=%h last=%b", value, last));
            return;
         end
         e = pending_elements.pop_front();
         if (value !== e.value)
            note_mismatch($sformatf("value expected %h got %h", e.value, value));
         if (last !== e.last)
            note_mismatch($sformatf("last expected %b got %b (value %h)", e.last, last, e.value));
      endfunction

      function int pending();
         return pending_elements.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [WORD_BITS-1:0]   req_packed_word = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [VALUE_W-1:0]     rsp_value;
   logic                   rsp_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   element_scoreboard sb = new();
   int stall_cycles = 0;
   int pop_hold = 0;
   bit calm = 1'b0;

   packed_bit_field_unpacker dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_packed_word  (req_packed_word),
      .empty            (empty),
      .pop              (pop),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // result side: random stalls, with calm stretches of steady pops
   always @(posedge clock) begin
      if ($urandom_range(0, 399) == 0)
         calm = !calm;
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop <= 1'b0;
         pop_hold--;
      end else begin
         pop <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0)
            pop_hold = gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_element(rsp_value, rsp_last);
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic push_word(logic [WORD_BITS-1:0] word, int gap);
      push <= 1'b1;
      req_packed_word <= word;
      do @(posedge clock); while (full);
      sb.absorb_word(word);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic feed(int n, bit bursty);
      int gap;
      for (int i = 0; i < n; i++) begin
         gap = (bursty || $urandom_range(0, 1)) ? 0 : gap_len();
         push_word(random_word(), gap);
      end
      push <= 1'b0;
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      sb.apply_register(index, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait for the last element, then let the engine drain
   task automatic settle();
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_width();
      logic [CSR_DATA_W-1:0] w;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      if ($urandom_range(0, 1))
         w |= $urandom() & ~32'h1F;
      return w;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         default: return $urandom_range(1, 48);
      endcase
   endfunction

   initial begin
      int random_words;
      int n;
      random_words = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: width 9, one element per stream
      push_word('1, 0);
      push_word('0, 2);
      push <= 1'b0;
      settle();

      // count zero acts as one, width 16
      csr_write(REG_ELEMENT_COUNT, '0);
      csr_write(REG_ELEMENT_WIDTH, 32'hFFFF_FFF0);
      push_word(64'h0123_4567_89AB_CDEF, 0);
      push_word('1, 0);
      push <= 1'b0;
      settle();

      // width 1 with junk above the field, endless stream
      csr_write(REG_ELEMENT_WIDTH, 32'hFFFF_FFE1);
      csr_write(REG_ELEMENT_COUNT, '1);
      push_word(64'hA5A5_A5A5_A5A5_A5A5, 0);
      push_word(64'h5A5A_5A5A_5A5A_5A5A, 3);
      push <= 1'b0;
      settle();

      // width zero acts as one; stream ends inside the second word
      csr_write(REG_ELEMENT_WIDTH, '0);
      csr_write(REG_ELEMENT_COUNT, 70);
      feed(2, 1'b1);
      settle();

      // width above sixteen clamps; padding after the last element is dropped
      csr_write(REG_ELEMENT_WIDTH, 31);
      csr_write(REG_ELEMENT_COUNT, 5);
      push_word('1, 0);
      push_word(64'hFEDC_BA98_7654_3210, 0);
      push <= 1'b0;
      settle();

      // straddling elements
      csr_write(REG_ELEMENT_WIDTH, 13);
      csr_write(REG_ELEMENT_COUNT, 20);
      push_word('0, 0);
      push_word('1, 0);
      feed(2, 1'b0);
      settle();

      // spare indexes must keep the carry, a count write must drop it
      csr_write(REG_ELEMENT_WIDTH, 11);
      csr_write(REG_ELEMENT_COUNT, 100);
      feed(1, 1'b1);
      settle();
      csr_write(REG_SPARE_LO, $urandom());
      csr_write(REG_SPARE_HI, $urandom());
      feed(1, 1'b1);
      settle();
      csr_write(REG_ELEMENT_COUNT, 100);
      feed(1, 1'b1);
      settle();

      csr_write(REG_ELEMENT_WIDTH, 17);
      csr_write(REG_ELEMENT_COUNT, 3);
      feed(2, 1'b1);
      settle();

      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 7))
            0: ;  // keep the running stream
            1: csr_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
            2: csr_write(REG_ELEMENT_WIDTH, random_width());
            3: csr_write(REG_ELEMENT_COUNT, random_count());
            default: begin
               if ($urandom_range(0, 1)) begin
                  csr_write(REG_ELEMENT_WIDTH, random_width());
                  csr_write(REG_ELEMENT_COUNT, random_count());
               end else begin
                  csr_write(REG_ELEMENT_COUNT, random_count());
                  csr_write(REG_ELEMENT_WIDTH, random_width());
               end
            end
         endcase
         // narrow elements give many elements per word, so fewer words are fed
         n = (sb.width_reg <= 4) ? $urandom_range(1, 4) : $urandom_range(2, 14);
         feed(n, $urandom_range(0, 3) == 0);
         random_words += n;
         settle();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/pbfu_pkg.sv
src/pbfu_front.sv
src/pbfu_back.sv
src/pbfu_rsp_queue.sv
src/packed_bit_field_unpacker.sv
verif/tb_packed_bit_field_unpacker.sv
